>>> hdl/ic_pkg.sv
// ----------------------------------------------------------------------------
// ic_pkg
// Types and constants shared by the inversion counter cells, tail and top.
// ----------------------------------------------------------------------------
package ic_pkg;

	localparam int MAX_ELEMENTS = 1024;
	localparam int VALUE_BITS   = 16;

	// per-token greater-than count: at most MAX_ELEMENTS-1
	localparam int CNT_W  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	// front-end fill counter, must hold MAX_ELEMENTS itself
	localparam int SEEN_W = $clog2(MAX_ELEMENTS + 1);

	localparam int INV_W  = 19;
	localparam int ELEM_W = 11;

	localparam logic [INV_W-1:0]  INV_MAX  = {INV_W{1'b1}};
	localparam logic [ELEM_W-1:0] ELEM_MAX = {ELEM_W{1'b1}};

	typedef struct packed {
		logic [15:0] value;
		logic        last;
	} item_t;

	typedef struct packed {
		logic [INV_W-1:0]  inversion_count;
		logic [ELEM_W-1:0] element_count;
		logic              overflow;
	} result_t;

	// token walking down the cell row
	typedef struct packed {
		logic                  valid;
		logic                  last;
		logic                  keep;   // counted element (not dropped)
		logic                  place;  // still looking for a free cell
		logic [VALUE_BITS-1:0] value;
		logic [CNT_W-1:0]      cnt;
	} tok_t;

endpackage

>>> hdl/ic_cell.sv
// ----------------------------------------------------------------------------
// ic_cell
// One compare cell: holds one stored element, counts it against each
// passing token, and hands the token on one cell per cycle while en is high.
// ----------------------------------------------------------------------------
module ic_cell (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  ic_pkg::tok_t tok_i,
	output ic_pkg::tok_t tok_o
);
	import ic_pkg::*;

	logic                  held_q;
	logic [VALUE_BITS-1:0] stored_q;
	tok_t                  tok_q;
	tok_t                  tok_nxt;
	logic                  greater;
	logic                  do_store;

	assign greater  = tok_i.valid && tok_i.keep && held_q && (stored_q > tok_i.value);
	assign do_store = tok_i.valid && tok_i.place && !tok_i.last && !held_q;

	always_comb begin
		tok_nxt = tok_i;
		if (greater) begin
			tok_nxt.cnt = tok_i.cnt + CNT_W'(1);
		end
		if (do_store) begin
			tok_nxt.place = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 1'b0;
			tok_q  <= '0;
		end else if (en) begin
			tok_q <= tok_nxt;
			// last beat of a sequence wipes every cell it passes
			if (tok_i.valid && tok_i.last) begin
				held_q <= 1'b0;
			end else if (do_store) begin
				held_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && do_store) begin
			stored_q <= tok_i.value;
		end
	end

	assign tok_o = tok_q;

endmodule

>>> hdl/ic_tail.sv
// ----------------------------------------------------------------------------
// ic_tail
// End of the cell row: sums token counts into the sequence totals and holds
// the result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module ic_tail (
	input  logic            clk,
	input  logic            arst_n,
	input  ic_pkg::tok_t    tok_i,
	output logic            adv,
	output logic            result_valid,
	input  logic            result_stall,
	output ic_pkg::result_t result
);
	import ic_pkg::*;

	logic [INV_W-1:0]  total_q;
	logic [ELEM_W-1:0] elem_q;
	logic              ovf_q;
	logic              rvalid_q;
	result_t           result_q;

	logic [INV_W:0]    inv_sum;
	logic [ELEM_W:0]   elem_sum;
	logic [INV_W-1:0]  total_nxt;
	logic [ELEM_W-1:0] elem_nxt;
	logic              ovf_nxt;

	// freeze the row only when a closing token meets a result still held
	assign adv = !(tok_i.valid && tok_i.last && rvalid_q && result_stall);

	always_comb begin
		inv_sum   = {1'b0, total_q} + (INV_W+1)'(tok_i.cnt);
		elem_sum  = {1'b0, elem_q} + (ELEM_W+1)'(tok_i.keep);
		total_nxt = inv_sum[INV_W] ? INV_MAX : inv_sum[INV_W-1:0];
		elem_nxt  = elem_sum[ELEM_W] ? ELEM_MAX : elem_sum[ELEM_W-1:0];
		ovf_nxt   = ovf_q || !tok_i.keep;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= '0;
			elem_q   <= '0;
			ovf_q    <= 1'b0;
			rvalid_q <= 1'b0;
		end else begin
			// a new closing token refills the result beat as the old one leaves
			if (adv && tok_i.valid && tok_i.last) begin
				rvalid_q <= 1'b1;
			end else if (!result_stall) begin
				rvalid_q <= 1'b0;
			end
			if (adv && tok_i.valid) begin
				if (tok_i.last) begin
					total_q <= '0;
					elem_q  <= '0;
					ovf_q   <= 1'b0;
				end else begin
					total_q <= total_nxt;
					elem_q  <= elem_nxt;
					ovf_q   <= ovf_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && tok_i.valid && tok_i.last) begin
			result_q.inversion_count <= total_nxt;
			result_q.element_count   <= elem_nxt;
			result_q.overflow        <= ovf_nxt;
		end
	end

	assign result_valid = rvalid_q;
	assign result       = result_q;

endmodule

>>> hdl/inversion_counter.sv
// ----------------------------------------------------------------------------
// inversion_counter
// Streams a sequence through a row of compare cells and reports the number
// of strictly inverted pairs when the beat marked last has passed the row.
// ----------------------------------------------------------------------------
//  channel   signals                           dir  beat type
//  item      item_valid / item_stall / item    in   item_t   (value, last)
//  result    result_valid / result_stall /     out  result_t (counts, overflow)
//            result
//
// One item beat per cycle unless stalled; each beat walks the row one cell per
// cycle unless frozen; the tail registers the result when the last beat exits.
// Reset clears the cell occupancy bits and counters; no clearing pass.
// The whole row freezes (and item_stall rises) only when a closing beat
// reaches the tail while the previous result is still stalled.
// ----------------------------------------------------------------------------
module inversion_counter (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  ic_pkg::item_t   item,
	output logic            result_valid,
	input  logic            result_stall,
	output ic_pkg::result_t result
);
	import ic_pkg::*;

	logic              adv;
	logic              accept;
	logic              keep;
	logic [SEEN_W-1:0] seen_q;
	tok_t              inject;
	tok_t              chain [MAX_ELEMENTS+1];

	assign item_stall = !adv;
	assign accept     = item_valid && adv;
	assign keep       = seen_q < SEEN_W'(MAX_ELEMENTS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (accept) begin
			if (item.last) begin
				seen_q <= '0;
			end else if (keep) begin
				seen_q <= seen_q + SEEN_W'(1);
			end
		end
	end

	// injected token; a bubble when nothing is accepted
	always_comb begin
		inject.valid = accept;
		inject.last  = item.last;
		inject.keep  = keep;
		inject.place = keep;
		inject.value = item.value[VALUE_BITS-1:0];
		inject.cnt   = '0;
	end

	assign chain[0] = inject;

	for (genvar k = 0; k < MAX_ELEMENTS; k++) begin : g_cell
		ic_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (adv),
			.tok_i (chain[k]),
			.tok_o (chain[k+1])
		);
	end

	ic_tail u_tail (
		.clk         (clk),
		.arst_n      (arst_n),
		.tok_i       (chain[MAX_ELEMENTS]),
		.adv         (adv),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for inversion_counter. Streams directed and random
// sequences, computes each sequence's expected totals as its closing beat is
// accepted, and checks every result beat field by field. Both sides idle at
// random, with one long result hold-off that backs up the row.
// ----------------------------------------------------------------------------
module tb_top;
	import ic_pkg::*;

	localparam int HOLD_START  = 1200;
	localparam int HOLD_CYCLES = 3000;
	localparam int SETTLE      = MAX_ELEMENTS + 100;
	localparam int RANDOM_BEATS = 530;

	typedef enum {SPREAD_FULL, SPREAD_LOW, SPREAD_TOP} spread_t;

	logic    clk        = 1'b0;
	logic    arst_n     = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item       = '0;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	logic rx_busy = 1'b0;
	logic rx_hold = 1'b0;
	assign result_stall = rx_busy | rx_hold;

	// expected-behavior state
	logic [VALUE_BITS-1:0] held_vals [MAX_ELEMENTS];
	int      held_count = 0;
	longint  pair_total = 0;
	bit      dropped    = 1'b0;
	result_t pending_totals [$];
	item_t   beats_to_send [$];

	int gap_left, busy_left, hold_left, cycle_count;
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	int error_count        = 0;
	int beats_in           = 0;
	int totals_seen        = 0;
	int overflow_seen      = 0;
	int input_stall_cycles = 0;

	inversion_counter uut (
		.clk,
		.arst_n,
		.item_valid,
		.item_stall,
		.item,
		.result_valid,
		.result_stall,
		.result
	);

	always #1 clk = ~clk;

	// fold one accepted beat into the running totals; closing beat emits a total
	task automatic count_inversions(item_t b);
		logic [VALUE_BITS-1:0] v;
		int      greater;
		result_t t;
		v = b.value[VALUE_BITS-1:0];
		if (held_count < MAX_ELEMENTS) begin
			greater = 0;
			for (int k = 0; k < held_count; k++)
				if (held_vals[k] > v)
					greater++;
			pair_total += greater;
			held_vals[held_count] = v;
			held_count++;
		end else begin
			dropped = 1'b1;
		end
		if (b.last) begin
			t.inversion_count = (pair_total > INV_MAX) ? INV_MAX : pair_total[INV_W-1:0];
			t.element_count   = (held_count > ELEM_MAX) ? ELEM_MAX : ELEM_W'(held_count);
			t.overflow        = dropped;
			pending_totals.push_back(t);
			pair_total = 0;
			held_count = 0;
			dropped    = 1'b0;
		end
	endtask

	task automatic queue_beat(int v, bit is_last);
		item_t b;
		b.value = v[15:0];
		b.last  = is_last;
		beats_to_send.push_back(b);
	endtask

	// item sender
	always @(posedge clk or negedge arst_n) begin : send_beats
		int wait_now;
		if (!arst_n) begin
			item_valid <= 1'b0;
			item       <= '0;
			gap_left   <= 0;
		end else begin
			if (item_valid && item_stall)
				input_stall_cycles++;
			if (item_valid && !item_stall) begin
				count_inversions(item);
				beats_in++;
				if (beats_in % 64 == 0)
					tx_steady = ($urandom_range(0, 3) == 0);
				wait_now = tx_steady ? 0 : $urandom_range(0, 12);
				if (wait_now == 0 && beats_to_send.size() != 0) begin
					item <= beats_to_send.pop_front();
				end else begin
					item_valid <= 1'b0;
					gap_left   <= (wait_now > 0) ? wait_now - 1 : 0;
				end
			end else if (!item_valid) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
				end else if (beats_to_send.size() != 0) begin
					item       <= beats_to_send.pop_front();
					item_valid <= 1'b1;
				end
			end
		end
	end

	// result receiver and checker
	always @(posedge clk or negedge arst_n) begin : take_results
		int      wait_now;
		result_t want;
		if (!arst_n) begin
			rx_busy   <= 1'b0;
			busy_left <= 0;
		end else if (result_valid && !result_stall) begin
			if (pending_totals.size() == 0) begin
				$error("result beat with no sequence total pending");
				error_count++;
			end else begin
				want = pending_totals.pop_front();
				if (result.inversion_count !== want.inversion_count) begin
					$error("inversion_count: expected %0d, got %0d",
						want.inversion_count, result.inversion_count);
					error_count++;
				end
				if (result.element_count !== want.element_count) begin
					$error("element_count: expected %0d, got %0d",
						want.element_count, result.element_count);
					error_count++;
				end
				if (result.overflow !== want.overflow) begin
					$error("overflow: expected %0d, got %0d",
						want.overflow, result.overflow);
					error_count++;
				end
			end
			totals_seen++;
			if (result.overflow === 1'b1)
				overflow_seen++;
			if (totals_seen % 8 == 0)
				rx_steady = ($urandom_range(0, 3) == 0);
			wait_now = rx_steady ? 0 : $urandom_range(0, 12);
			rx_busy   <= (wait_now != 0);
			busy_left <= wait_now;
		end else if (busy_left > 0) begin
			busy_left <= busy_left - 1;
			rx_busy   <= (busy_left > 1);
		end
	end

	// one long hold-off on the result side so the row backs up into item_stall
	always @(posedge clk or negedge arst_n) begin : long_hold
		if (!arst_n) begin
			rx_hold     <= 1'b0;
			hold_left   <= 0;
			cycle_count <= 0;
		end else begin
			cycle_count <= cycle_count + 1;
			if (cycle_count == HOLD_START) begin
				rx_hold   <= 1'b1;
				hold_left <= HOLD_CYCLES;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				rx_hold   <= (hold_left > 1);
			end
		end
	end

	initial begin : stimulus
		int      len;
		int      v;
		int      random_sent;
		spread_t spread;

		// single-element sequences at both extremes
		queue_beat(0, 1'b1);
		queue_beat(16'hFFFF, 1'b1);
		// one inverted pair, then one ordered pair
		queue_beat(16'hFFFF, 1'b0);
		queue_beat(0, 1'b1);
		queue_beat(0, 1'b0);
		queue_beat(16'hFFFF, 1'b1);
		// equal values never count
		queue_beat(16'h5A5A, 1'b0);
		queue_beat(16'h5A5A, 1'b0);
		queue_beat(16'h5A5A, 1'b1);
		// alternating bit patterns, mixed order
		queue_beat(16'hAAAA, 1'b0);
		queue_beat(16'h5555, 1'b0);
		queue_beat(16'hAAAA, 1'b0);
		queue_beat(16'h5555, 1'b0);
		queue_beat(16'h8000, 1'b0);
		queue_beat(16'h0001, 1'b0);
		queue_beat(16'h7FFF, 1'b1);
		// strictly descending
		queue_beat(40000, 1'b0);
		queue_beat(30000, 1'b0);
		queue_beat(20000, 1'b0);
		queue_beat(1, 1'b1);

		random_sent = 0;
		while (random_sent < RANDOM_BEATS) begin
			len    = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
			spread = spread_t'($urandom_range(0, 2));
			for (int i = 0; i < len; i++) begin
				case (spread)
					SPREAD_FULL: v = $urandom_range(0, 65535);
					SPREAD_LOW:  v = $urandom_range(0, 3);
					default:     v = 65535 - $urandom_range(0, 3);
				endcase
				queue_beat(v, i == len - 1);
			end
			random_sent += len;
		end

		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (beats_to_send.size() != 0 || item_valid)
			@(posedge clk);
		while (pending_totals.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("Sent %0d item beats and checked %0d sequence totals (%0d with overflow).",
			beats_in, totals_seen, overflow_seen);
		$display("Input was held back for %0d cycles while results were stalled.",
			input_stall_cycles);
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin : watchdog
		#400_000;
		$display("Verification failed");
		$finish;
	end

endmodule

>>> filelist.f
hdl/ic_pkg.sv
hdl/ic_cell.sv
hdl/ic_tail.sv
hdl/inversion_counter.sv
sim/tb_top.sv
